/* rtl/core/pfhm_pkg.sv */
`default_nettype none

package pfhm_pkg;

  // item kinds carried on in_tuser
  localparam logic [2:0] OP_FRAME = 3'd0;
  localparam logic [2:0] OP_POLL  = 3'd1;
  localparam logic [2:0] OP_RXERR = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_ID     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXPECTED_PERIOD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REJECT_EXT      = 3'd4;

  // register reset values
  localparam logic [10:0] RST_EXPECTED_ID     = 11'd256;
  localparam logic [15:0] RST_EXPECTED_PERIOD = 16'd100;
  localparam logic [15:0] RST_TOLERANCE       = 16'd20;
  localparam logic [15:0] RST_TIMEOUT         = 16'd500;
  localparam logic        RST_REJECT_EXT      = 1'b1;

  // only full eight byte frames carry a valid counter
  localparam logic [3:0] REQUIRED_LENGTH = 4'd8;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 280;

  typedef enum logic [2:0] {
    ST_STOPPED   = 3'd0,
    ST_WAITING   = 3'd1,
    ST_HEALTHY   = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_PERIOD    = 3'd4,
    ST_COUNTER   = 3'd5,
    ST_MALFORMED = 3'd6,
    ST_IOERR     = 3'd7
  } state_t;

  typedef struct packed {
    logic [10:0] monitored_id;
    logic [15:0] expected_period_ms;
    logic [15:0] period_tolerance_ms;
    logic [15:0] timeout_ms;
    logic        reject_extended;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [10:0] frame_id;
    logic        frame_extended;
    logic [3:0]  frame_length;
    logic [7:0]  counter_low_byte;
    logic [7:0]  counter_high_byte;
  } item_t;

  typedef struct packed {
    state_t      monitor_state;
    logic        state_changed;
    logic        healthy;
    logic [31:0] last_gap_ms;
    logic [15:0] last_sequence;
    logic [31:0] frames_seen;
    logic [31:0] frames_ignored;
    logic [31:0] period_fault_count;
    logic [31:0] sequence_fault_count;
    logic [31:0] length_fault_count;
    logic [31:0] receive_fault_count;
    logic [31:0] age_ms;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/pfhm_cfg.sv */
`default_nettype none

module pfhm_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pfhm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [pfhm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pfhm_pkg::cfg_t                        cfg
);

  pfhm_pkg::cfg_t cfg_r;
  pfhm_pkg::cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        pfhm_pkg::CFG_EXPECTED_ID:     cfg_nxt.monitored_id = cfg_wdata[10:0];
        pfhm_pkg::CFG_EXPECTED_PERIOD: cfg_nxt.expected_period_ms = cfg_wdata;
        pfhm_pkg::CFG_TOLERANCE:       cfg_nxt.period_tolerance_ms = cfg_wdata;
        pfhm_pkg::CFG_TIMEOUT:         cfg_nxt.timeout_ms = cfg_wdata;
        pfhm_pkg::CFG_REJECT_EXT:      cfg_nxt.reject_extended = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.monitored_id        <= pfhm_pkg::RST_EXPECTED_ID;
      cfg_r.expected_period_ms  <= pfhm_pkg::RST_EXPECTED_PERIOD;
      cfg_r.period_tolerance_ms <= pfhm_pkg::RST_TOLERANCE;
      cfg_r.timeout_ms          <= pfhm_pkg::RST_TIMEOUT;
      cfg_r.reject_extended     <= pfhm_pkg::RST_REJECT_EXT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/pfhm_engine.sv */
`default_nettype none

module pfhm_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire pfhm_pkg::item_t item,
  input  wire pfhm_pkg::cfg_t  cfg,
  output pfhm_pkg::result_t res
);

  // monitor state
  logic            run_r, run_nxt;
  pfhm_pkg::state_t state_r, state_nxt;
  logic [31:0]     start_r, start_nxt;
  logic [31:0]     last_rx_r, last_rx_nxt;
  logic [31:0]     meas_r, meas_nxt;
  logic [15:0]     prev_seq_r, prev_seq_nxt;
  logic            tv_r, tv_nxt;
  logic            sv_r, sv_nxt;
  logic            sync_r, sync_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     ign_r, ign_nxt;
  logic [31:0]     per_err_r, per_err_nxt;
  logic [31:0]     seq_err_r, seq_err_nxt;
  logic [31:0]     len_err_r, len_err_nxt;
  logic [31:0]     rx_err_r, rx_err_nxt;

  logic [15:0] seq;
  logic [31:0] gap;
  logic [31:0] age_pre;
  logic [15:0] lower_b;
  logic [16:0] upper_b;
  logic        id_match;
  logic        rebase;
  logic        gap_ok;
  logic        seq_ok;

  // frame decode and period window
  assign seq      = {item.counter_high_byte, item.counter_low_byte};
  assign gap      = item.now_ms - last_rx_r;
  assign age_pre  = item.now_ms - ((acc_r == 32'd0) ? start_r : last_rx_r);
  assign lower_b  = (cfg.expected_period_ms > cfg.period_tolerance_ms) ?
                    (cfg.expected_period_ms - cfg.period_tolerance_ms) : 16'd0;
  assign upper_b  = {1'b0, cfg.expected_period_ms} + {1'b0, cfg.period_tolerance_ms};
  assign id_match = !(item.frame_extended && cfg.reject_extended) &&
                    (item.frame_id == cfg.monitored_id);
  assign rebase   = sync_r && (!tv_r || (gap < {16'd0, lower_b}));
  assign gap_ok    = !tv_r || ((gap >= {16'd0, lower_b}) && (gap <= {15'd0, upper_b}));
  assign seq_ok    = !sv_r || (seq == (prev_seq_r + 16'd1));

  // single pass update for one item
  always_comb begin
    run_nxt      = run_r;
    state_nxt    = state_r;
    start_nxt    = start_r;
    last_rx_nxt  = last_rx_r;
    meas_nxt     = meas_r;
    prev_seq_nxt = prev_seq_r;
    tv_nxt       = tv_r;
    sv_nxt       = sv_r;
    sync_nxt     = sync_r;
    acc_nxt      = acc_r;
    ign_nxt      = ign_r;
    per_err_nxt  = per_err_r;
    seq_err_nxt  = seq_err_r;
    len_err_nxt  = len_err_r;
    rx_err_nxt   = rx_err_r;
    if (item.opcode == pfhm_pkg::OP_START) begin
      if (!run_r) begin
        run_nxt      = 1'b1;
        start_nxt    = item.now_ms;
        last_rx_nxt  = item.now_ms;
        meas_nxt     = 32'd0;
        prev_seq_nxt = 16'd0;
        tv_nxt       = 1'b0;
        sv_nxt       = 1'b0;
        sync_nxt     = 1'b1;
        acc_nxt      = 32'd0;
        ign_nxt      = 32'd0;
        per_err_nxt  = 32'd0;
        seq_err_nxt  = 32'd0;
        len_err_nxt  = 32'd0;
        rx_err_nxt   = 32'd0;
        state_nxt    = pfhm_pkg::ST_WAITING;
      end
    end else if (run_r) begin
      case (item.opcode)
        pfhm_pkg::OP_STOP: begin
          run_nxt   = 1'b0;
          state_nxt = pfhm_pkg::ST_STOPPED;
        end
        pfhm_pkg::OP_POLL: begin
          if ((age_pre > {16'd0, cfg.timeout_ms}) &&
              (state_r != pfhm_pkg::ST_TIMEOUT)) begin
            state_nxt = pfhm_pkg::ST_TIMEOUT;
            tv_nxt    = 1'b0;
            sv_nxt    = 1'b0;
          end
        end
        pfhm_pkg::OP_RXERR: begin
          rx_err_nxt = rx_err_r + 32'd1;
          state_nxt  = pfhm_pkg::ST_IOERR;
        end
        pfhm_pkg::OP_FRAME: begin
          if (!id_match) begin
            ign_nxt = ign_r + 32'd1;
          end else if (item.frame_length != pfhm_pkg::REQUIRED_LENGTH) begin
            len_err_nxt = len_err_r + 32'd1;
            state_nxt   = pfhm_pkg::ST_MALFORMED;
          end else begin
            prev_seq_nxt = seq;
            tv_nxt       = 1'b1;
            sv_nxt       = 1'b1;
            last_rx_nxt  = item.now_ms;
            acc_nxt      = acc_r + 32'd1;
            if (rebase) begin
              // startup sync: move the baseline, state unchanged
              meas_nxt = 32'd0;
            end else begin
              sync_nxt = 1'b0;
              if (tv_r) begin
                meas_nxt = gap;
              end
              if (!gap_ok) begin
                per_err_nxt = per_err_r + 32'd1;
              end
              if (!seq_ok) begin
                seq_err_nxt = seq_err_r + 32'd1;
              end
              if (!gap_ok) begin
                state_nxt = pfhm_pkg::ST_PERIOD;
              end else if (!seq_ok) begin
                state_nxt = pfhm_pkg::ST_COUNTER;
              end else begin
                state_nxt = pfhm_pkg::ST_HEALTHY;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result fields from the updated state
  always_comb begin
    res.monitor_state        = state_nxt;
    res.state_changed        = (state_nxt != state_r);
    res.healthy              = run_nxt && (state_nxt == pfhm_pkg::ST_HEALTHY);
    res.last_gap_ms          = meas_nxt;
    res.last_sequence        = prev_seq_nxt;
    res.frames_seen          = acc_nxt;
    res.frames_ignored       = ign_nxt;
    res.period_fault_count   = per_err_nxt;
    res.sequence_fault_count = seq_err_nxt;
    res.length_fault_count   = len_err_nxt;
    res.receive_fault_count  = rx_err_nxt;
    res.age_ms = item.now_ms - ((acc_nxt == 32'd0) ? start_nxt : last_rx_nxt);
  end

  // state registers advance once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      state_r    <= pfhm_pkg::ST_STOPPED;
      start_r    <= 32'd0;
      last_rx_r  <= 32'd0;
      meas_r     <= 32'd0;
      prev_seq_r <= 16'd0;
      tv_r       <= 1'b0;
      sv_r       <= 1'b0;
      sync_r     <= 1'b0;
      acc_r      <= 32'd0;
      ign_r      <= 32'd0;
      per_err_r  <= 32'd0;
      seq_err_r  <= 32'd0;
      len_err_r  <= 32'd0;
      rx_err_r   <= 32'd0;
    end else if (step) begin
      run_r      <= run_nxt;
      state_r    <= state_nxt;
      start_r    <= start_nxt;
      last_rx_r  <= last_rx_nxt;
      meas_r     <= meas_nxt;
      prev_seq_r <= prev_seq_nxt;
      tv_r       <= tv_nxt;
      sv_r       <= sv_nxt;
      sync_r     <= sync_nxt;
      acc_r      <= acc_nxt;
      ign_r      <= ign_nxt;
      per_err_r  <= per_err_nxt;
      seq_err_r  <= seq_err_nxt;
      len_err_r  <= len_err_nxt;
      rx_err_r   <= rx_err_nxt;
    end
  end

  // stopped monitor always reports the stopped state
  a_stopped_state: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (state_r == pfhm_pkg::ST_STOPPED))
    else $error("monitor not running but state is not stopped");

  // items other than start leave a stopped monitor stopped
  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !run_r && (item.opcode != pfhm_pkg::OP_START)) |=> !run_r)
    else $error("non-start item woke a stopped monitor");

endmodule

`default_nettype wire

/* rtl/core/periodic_frame_health_monitor_unit.sv */
`default_nettype none

// Supervises one periodic CAN frame: start/stop, timeout poll, receive error and received
// frame items come in on the in_ stream, and every item produces exactly one status
// transfer on the out_ stream (state, changed and healthy flags, last period, last rolling
// counter, age and six wrapping counters). One item is accepted per clock cycle while the
// out_ stream is not stalled; an item passes the input register, then the single-pass
// update logic into the result register, where the state update of each item completes,
// so consecutive items never wait on each other. Configuration registers are written
// through the cfg_ port and should only change while the stream is idle.
module periodic_frame_health_monitor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [pfhm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [pfhm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // now_ms[31:0], frame_id[42:32], frame_extended[43], frame_length[47:44],
  // counter_low_byte[55:48], counter_high_byte[63:56]
  input  wire logic [pfhm_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode[2:0]
  input  wire logic [pfhm_pkg::IN_USER_W-1:0]    in_tuser,
  // result stream
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // monitor_state[2:0], state_changed[3], healthy[4], last_gap_ms[36:5],
  // last_sequence[52:37], frames_seen[84:53], frames_ignored[116:85],
  // period_fault_count[148:117], sequence_fault_count[180:149],
  // length_fault_count[212:181], receive_fault_count[244:213], age_ms[276:245],
  // zero [279:277]
  output      logic [pfhm_pkg::OUT_DATA_W-1:0]   out_tdata
);

  pfhm_pkg::cfg_t    cfg;
  pfhm_pkg::item_t   item_r;
  pfhm_pkg::result_t res;
  logic              item_vld_r;
  logic              advance;
  logic              out_vld_r;
  logic [pfhm_pkg::OUT_DATA_W-1:0] out_data_r;

  pfhm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // item moves into the update stage when the result register is free
  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.opcode            <= in_tuser;
      item_r.now_ms            <= in_tdata[31:0];
      item_r.frame_id          <= in_tdata[42:32];
      item_r.frame_extended    <= in_tdata[43];
      item_r.frame_length      <= in_tdata[47:44];
      item_r.counter_low_byte  <= in_tdata[55:48];
      item_r.counter_high_byte <= in_tdata[63:56];
    end
  end

  pfhm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {3'b000, res.age_ms, res.receive_fault_count, res.length_fault_count,
                     res.sequence_fault_count, res.period_fault_count, res.frames_ignored,
                     res.frames_seen, res.last_sequence, res.last_gap_ms, res.healthy,
                     res.state_changed, res.monitor_state};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // an item waiting behind a stalled result keeps its contents
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !advance) |=> (item_vld_r && $stable(item_r)))
    else $error("pending item lost or changed while stalled");

  // no new transfer while both stages are full and the result is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && out_vld_r && !out_tready) |-> !in_tready)
    else $error("input accepted with both stages full");

  // a stalled result is not overwritten
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
